// ----- rtl/core/lcdnw_pkg.sv -----
`default_nettype none

package lcdnw_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_INSTR = 2'd2,
    CMD_GOTO  = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE0_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE1_BASE = 1'b1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [6:0] LINE0_BASE_RST = 7'd0;
  localparam logic [6:0] LINE1_BASE_RST = 7'd64;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Timing in microseconds
  localparam logic [14:0] LEAD_POWER_US = 15'd20000;
  localparam logic [14:0] LEAD_NONE_US  = 15'd0;
  localparam logic [12:0] WAIT_PULSE_US = 13'd2;
  localparam logic [12:0] WAIT_SHORT_US = 13'd62;
  localparam logic [12:0] WAIT_LONG_US  = 13'd2002;
  localparam logic [12:0] WAIT_WAKE_US  = 13'd5002;
  localparam logic [12:0] WAIT_INIT_US  = 13'd1002;

  localparam logic [7:0] INSTR_CLEAR = 8'h01;
  localparam logic [7:0] INSTR_HOME  = 8'h02;
  localparam logic [7:0] INSTR_DDRAM = 8'h80;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
    logic [6:0] column;
    logic       row;
  } req_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [14:0] lead_us;
    logic [12:0] wait_us;
    logic        last;
  } rsp_t;

  // Classified job between front and back
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] bval;
  } job_t;

  function automatic rsp_t mk_word(logic rs, logic [3:0] nib, logic [14:0] lead,
                                   logic [12:0] wt, logic last);
    rsp_t w;
    w.rs      = rs;
    w.nibble  = nib;
    w.lead_us = lead;
    w.wait_us = wt;
    w.last    = last;
    return w;
  endfunction

  // Power-on init run: wake-up nibbles, the 4-bit switch, then 0x28 0x08 0x01 0x06 0x0C
  function automatic rsp_t init_word(logic [3:0] step);
    rsp_t w;
    case (step)
      4'd0:    w = mk_word(1'b0, 4'h3, LEAD_POWER_US, WAIT_WAKE_US, 1'b0);
      4'd1:    w = mk_word(1'b0, 4'h3, LEAD_NONE_US, WAIT_INIT_US, 1'b0);
      4'd2:    w = mk_word(1'b0, 4'h3, LEAD_NONE_US, WAIT_INIT_US, 1'b0);
      4'd3:    w = mk_word(1'b0, 4'h2, LEAD_NONE_US, WAIT_INIT_US, 1'b0);
      4'd4:    w = mk_word(1'b0, 4'h2, LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
      4'd5:    w = mk_word(1'b0, 4'h8, LEAD_NONE_US, WAIT_SHORT_US, 1'b0);
      4'd6:    w = mk_word(1'b0, 4'h0, LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
      4'd7:    w = mk_word(1'b0, 4'h8, LEAD_NONE_US, WAIT_SHORT_US, 1'b0);
      4'd8:    w = mk_word(1'b0, 4'h0, LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
      4'd9:    w = mk_word(1'b0, 4'h1, LEAD_NONE_US, WAIT_LONG_US, 1'b0);
      4'd10:   w = mk_word(1'b0, 4'h0, LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
      4'd11:   w = mk_word(1'b0, 4'h6, LEAD_NONE_US, WAIT_SHORT_US, 1'b0);
      4'd12:   w = mk_word(1'b0, 4'h0, LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
      default: w = mk_word(1'b0, 4'hC, LEAD_NONE_US, WAIT_SHORT_US, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/char_lcd_nibble_write_sequencer.sv -----
// Path: an accepted request waits in the job queue, then the back sequencer registers its
//   words in the output register driving out_data_o; a byte request is 2 words, init 14.
// Throughput: one word per cycle from the back sequencer, unless out_stall_i holds it; the
//   front takes a new request each cycle while the job queue has room.
// Reset: rst_ni is asynchronous, active low; it empties the queue and output register and
//   sets line0_base to 0 and line1_base to 64.
`default_nettype none

module char_lcd_nibble_write_sequencer
  import lcdnw_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire req_t                  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output rsp_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  job_t front_job;
  job_t head_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic q_push;

  // Front: hold the line bases, turn each request into a job (init run or one byte)
  lcdnw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_data_i),
    .job_o      (front_job)
  );

  // Stall the requester only while the queue is full
  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  lcdnw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (head_job)
  );

  // Back: one nibble word of the head job per unstalled cycle, dropped after its last word
  lcdnw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Only the first init word carries the power-on lead
  a_lead_first_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.lead_us != LEAD_NONE_US) |->
      out_data_o.nibble == 4'h3 && !out_data_o.rs && out_data_o.wait_us == WAIT_WAKE_US
      && !out_data_o.last)
    else $error("power-on lead on a word other than the first init write");

  // Data words never take the long instruction wait
  a_data_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rs |->
      out_data_o.wait_us == WAIT_PULSE_US || out_data_o.wait_us == WAIT_SHORT_US)
    else $error("bad wait on a data word");

  // A queue pop only happens on the word that closes a run
  a_pop_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_valid_o && out_data_o.last)
    else $error("job dropped before its last word");

  // A full queue stays full until a job is popped
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && !q_pop |=> q_full)
    else $error("job queue lost an entry");

endmodule

`default_nettype wire

// ----- rtl/core/lcdnw_front.sv -----
`default_nettype none

module lcdnw_front
  import lcdnw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire req_t                  req_i,
  output job_t                       job_o
);

  logic [6:0] line0_q;
  logic [6:0] line1_q;
  logic [6:0] base;
  logic [7:0] addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line0_q <= LINE0_BASE_RST;
      line1_q <= LINE1_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE0_BASE: line0_q <= cfg_data_i;
        CFG_LINE1_BASE: line1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cursor address: line base plus column in 8 bits (at most 254, so it never wraps)
  assign base = req_i.row ? line1_q : line0_q;
  assign addr = {1'b0, base} + {1'b0, req_i.column};

  always_comb begin
    job_o.is_init = 1'b0;
    job_o.rs      = 1'b0;
    job_o.bval    = req_i.value;
    case (cmd_e'(req_i.cmd))
      CMD_INIT:  job_o.is_init = 1'b1;
      CMD_DATA:  job_o.rs      = 1'b1;
      CMD_INSTR: job_o.rs      = 1'b0;
      CMD_GOTO:  job_o.bval    = INSTR_DDRAM | addr;
      default:   job_o.rs      = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcdnw_queue.sv -----
`default_nettype none

module lcdnw_queue
  import lcdnw_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lcdnw_back.sv -----
`default_nettype none

module lcdnw_back
  import lcdnw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  rsp_t       out_data_q, out_data_d;
  rsp_t       word;
  logic       long_wait;
  logic       advance;

  assign long_wait = !job_i.rs && (job_i.bval == INSTR_CLEAR || job_i.bval == INSTR_HOME);

  always_comb begin
    if (job_i.is_init) begin
      word = init_word(step_q);
    end else if (step_q == 4'd0) begin
      word = mk_word(job_i.rs, job_i.bval[7:4], LEAD_NONE_US, WAIT_PULSE_US, 1'b0);
    end else begin
      word = mk_word(job_i.rs, job_i.bval[3:0], LEAD_NONE_US,
                     long_wait ? WAIT_LONG_US : WAIT_SHORT_US, 1'b1);
    end
  end

  assign advance = !out_valid_q || !out_stall_i;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    if (advance) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        out_data_d = word;
        if (word.last) begin
          step_d = '0;
          pop_o  = 1'b1;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- sim/char_lcd_nibble_write_sequencer_test.sv -----
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_test;
  import lcdnw_pkg::*;

  // Bus timing in microseconds. Every wait already holds the 2 us enable-low tail.
  localparam logic [14:0] POWER_ON_LEAD = 15'd20000;
  localparam logic [14:0] NO_LEAD       = 15'd0;
  localparam logic [12:0] NIBBLE_GAP    = 13'd2;
  localparam logic [12:0] BYTE_GAP      = 13'd62;
  localparam logic [12:0] SLOW_BYTE_GAP = 13'd2002;
  localparam logic [12:0] WAKE_GAP      = 13'd5002;
  localparam logic [12:0] FUNC_SET_GAP  = 13'd1002;

  localparam logic [3:0] WAKE_NIBBLE   = 4'h3;
  localparam logic [3:0] FOUR_BIT_MODE = 4'h2;

  // Init command bytes, first one in the top bits.
  localparam logic [39:0] INIT_BYTES = {8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

  // Cycles to let the block settle once nothing is outstanding.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  req_t                  in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  rsp_t                  out_data_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  char_lcd_nibble_write_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the two line-base registers.
  logic [6:0] line0_base_q = LINE0_BASE_RST;
  logic [6:0] line1_base_q = LINE1_BASE_RST;

  // Nibble words still owed by the block, oldest first.
  rsp_t        pending_words[$];
  rsp_t        oldest_word;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned errors        = 0;
  int unsigned words_checked = 0;
  int unsigned kind_count[4];
  int unsigned base_writes   = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("char_lcd_nibble_write_sequencer test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Queue one bus write as an expected word.
  task automatic owe_nibble(input logic rs, input logic [3:0] nib, input logic [14:0] lead,
                            input logic [12:0] gap, input logic is_last);
    rsp_t w;
    w.rs      = rs;
    w.nibble  = nib;
    w.lead_us = lead;
    w.wait_us = gap;
    w.last    = is_last;
    pending_words.push_back(w);
  endtask

  // A byte goes out high nibble first; clear and home need the long wait,
  // but only on the instruction register.
  task automatic owe_byte(input logic rs, input logic [7:0] b, input logic is_last);
    logic [12:0] tail;
    if (!rs && (b == INSTR_CLEAR || b == INSTR_HOME)) begin
      tail = SLOW_BYTE_GAP;
    end else begin
      tail = BYTE_GAP;
    end
    owe_nibble(rs, b[7:4], NO_LEAD, NIBBLE_GAP, 1'b0);
    owe_nibble(rs, b[3:0], NO_LEAD, tail, is_last);
  endtask

  // Work out every word that one accepted request must produce.
  task automatic owe_request_words(input req_t r);
    logic [6:0] base;
    logic [7:0] addr;
    case (r.cmd)
      CMD_INIT: begin
        // Three wake-up nibbles, the 4-bit switch, then the setup bytes.
        owe_nibble(1'b0, WAKE_NIBBLE, POWER_ON_LEAD, WAKE_GAP, 1'b0);
        owe_nibble(1'b0, WAKE_NIBBLE, NO_LEAD, FUNC_SET_GAP, 1'b0);
        owe_nibble(1'b0, WAKE_NIBBLE, NO_LEAD, FUNC_SET_GAP, 1'b0);
        owe_nibble(1'b0, FOUR_BIT_MODE, NO_LEAD, FUNC_SET_GAP, 1'b0);
        for (int i = 0; i < 5; i++) begin
          owe_byte(1'b0, INIT_BYTES[39 - 8 * i -: 8], i == 4);
        end
      end
      CMD_DATA:  owe_byte(1'b1, r.value, 1'b1);
      CMD_INSTR: owe_byte(1'b0, r.value, 1'b1);
      default: begin
        // Goto: base plus column in 8 bits (it never wraps), with the set-address bit.
        base = r.row ? line1_base_q : line0_base_q;
        addr = {1'b0, base} + {1'b0, r.column};
        owe_byte(1'b0, INSTR_DDRAM | addr, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: word field %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    // Compare each accepted word against the oldest one owed.
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        oldest_word = pending_words.pop_front();
        check_field("rs", 16'(oldest_word.rs), 16'(out_data_o.rs));
        check_field("nibble", 16'(oldest_word.nibble), 16'(out_data_o.nibble));
        check_field("lead_us", 16'(oldest_word.lead_us), 16'(out_data_o.lead_us));
        check_field("wait_us", 16'(oldest_word.wait_us), 16'(out_data_o.wait_us));
        check_field("last", 16'(oldest_word.last), 16'(out_data_o.last));
        words_checked++;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t make_request(input cmd_e cmd, input logic [7:0] value,
                                        input logic [6:0] column, input logic row);
    req_t r;
    r.cmd    = cmd;
    r.value  = value;
    r.column = column;
    r.row    = row;
    return r;
  endfunction

  // Offer one request word and hold it until the block takes it.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    owe_request_words(r);
    kind_count[r.cmd]++;
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both line bases; the block must be idle first.
  task automatic set_line_bases(input logic [6:0] base0, input logic [6:0] base1);
    drain_words();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LINE0_BASE;
    cfg_data_i <= base0;
    @(posedge clk_i);
    line0_base_q = base0;
    cfg_idx_i  <= CFG_LINE1_BASE;
    cfg_data_i <= base1;
    @(posedge clk_i);
    line1_base_q = base1;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    base_writes++;
  endtask

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    pick     = $urandom_range(99);
    r.value  = 8'($urandom_range(255));
    r.row    = 1'($urandom_range(1));
    // Mostly columns on the display, sometimes past it so the sum runs far beyond it.
    r.column = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 80)) : 7'($urandom_range(79));
    if (pick < 5) begin
      r.cmd = CMD_INIT;
    end else if (pick < 40) begin
      r.cmd = CMD_DATA;
    end else if (pick < 70) begin
      r.cmd = CMD_INSTR;
      // Bias toward clear and home to hit the long wait often.
      if ($urandom_range(3) == 0) begin
        r.value = $urandom_range(1) ? INSTR_CLEAR : INSTR_HOME;
      end
    end else begin
      r.cmd = CMD_GOTO;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Goto with the line bases still at their reset values.
  task automatic test_goto_reset_bases();
    send_request(make_request(CMD_GOTO, 8'h00, 7'd0, 1'b0));
    send_request(make_request(CMD_GOTO, 8'hFF, 7'd0, 1'b1));
    send_request(make_request(CMD_GOTO, 8'h5A, 7'd79, 1'b1));
  endtask

  task automatic test_init_run();
    send_request(make_request(CMD_INIT, 8'hFF, 7'h7F, 1'b1));
  endtask

  task automatic test_data_bytes();
    send_request(make_request(CMD_DATA, 8'h00, 7'd0, 1'b0));
    send_request(make_request(CMD_DATA, 8'hFF, 7'h7F, 1'b1));
    send_request(make_request(CMD_DATA, 8'h01, 7'd0, 1'b0));
  endtask

  // Clear and home take the long wait; everything else the short one.
  task automatic test_command_bytes();
    send_request(make_request(CMD_INSTR, INSTR_CLEAR, 7'd0, 1'b0));
    send_request(make_request(CMD_INSTR, INSTR_HOME, 7'd0, 1'b0));
    send_request(make_request(CMD_INSTR, 8'h00, 7'd0, 1'b0));
    send_request(make_request(CMD_INSTR, 8'hFF, 7'd0, 1'b0));
    send_request(make_request(CMD_INSTR, 8'h03, 7'd0, 1'b0));
    send_request(make_request(CMD_INSTR, INSTR_DDRAM, 7'd0, 1'b0));
  endtask

  // Extreme line bases, including columns beyond the display.
  task automatic test_goto_line_bases();
    set_line_bases(7'd127, 7'd127);
    send_request(make_request(CMD_GOTO, 8'h00, 7'd127, 1'b0));
    send_request(make_request(CMD_GOTO, 8'h00, 7'd127, 1'b1));
    send_request(make_request(CMD_GOTO, 8'h00, 7'd0, 1'b0));
    set_line_bases(7'd0, 7'd0);
    send_request(make_request(CMD_GOTO, 8'h00, 7'd79, 1'b1));
    send_request(make_request(CMD_GOTO, 8'h00, 7'd80, 1'b0));
  endtask

  // Random traffic in four idle/stall mixes, with new line bases per mix.
  task automatic test_random_traffic();
    int unsigned send_mix[4];
    int unsigned stall_mix[4];
    send_mix  = '{0, 45, 0, 32};
    stall_mix = '{0, 0, 45, 32};
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       set_line_bases(7'd127, 7'd0);
        2:       set_line_bases(7'd0, 7'd127);
        default: set_line_bases(7'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      for (int n = 0; n < 65; n++) begin
        // Once, hold off the sender until the block has fully emptied.
        if (p == 1 && n == 30) drain_words();
        send_request(random_request());
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_goto_reset_bases();
    test_init_run();
    test_data_bytes();
    test_command_bytes();
    test_goto_line_bases();
    test_random_traffic();
    drain_words();

    $display("Covered %0d init, %0d data, %0d command and %0d goto requests, %0d words checked,",
             kind_count[CMD_INIT], kind_count[CMD_DATA], kind_count[CMD_INSTR],
             kind_count[CMD_GOTO], words_checked);
    $display("over %0d line-base settings and four sender-idle/receiver-stall mixes.",
             base_writes);
    if (errors == 0) begin
      $display("char_lcd_nibble_write_sequencer test passed");
    end else begin
      $display("char_lcd_nibble_write_sequencer test failed");
    end
    $finish;
  end

endmodule
